[hw/rtl/lcfs_pkg.sv]
// Shared types, constants and the color bit placement table for the LED cube scan core.
// No dependencies; every other file in the block depends on this package.
package lcfs_pkg;

    // Cube and frame geometry.
    localparam int unsigned NUM_PLANES  = 8;
    localparam int unsigned PLANE_W     = 3;
    localparam int unsigned SECTOR_W    = 3;
    localparam int unsigned WORD_W      = 24;
    localparam int unsigned BITPOS_W    = 5;
    localparam int unsigned NUM_COLORS  = 3;
    localparam int unsigned DWELL_W     = 16;

    // Reset value of the dwell register, in ticks.
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1250;

    // Request function codes.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [PLANE_W-1:0]  t_plane;
    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [BITPOS_W-1:0] t_bitpos;
    typedef logic [DWELL_W-1:0]  t_dwell;

    // Anode bit position of each color of a sector, ordered blue, green, red.
    localparam t_bitpos BIT_POS [NUM_PLANES][NUM_COLORS] = '{
        '{5'd7,  5'd6,  5'd5 },
        '{5'd3,  5'd2,  5'd1 },
        '{5'd4,  5'd15, 5'd14},
        '{5'd0,  5'd11, 5'd10},
        '{5'd13, 5'd12, 5'd23},
        '{5'd9,  5'd8,  5'd19},
        '{5'd22, 5'd21, 5'd20},
        '{5'd18, 5'd17, 5'd16}
    };

    // Pixel write request from the core to the frame store.
    typedef struct packed {
        logic       en;
        t_plane     plane;
        t_sector    sector;
        logic [2:0] rgb;
    } t_pix_wr;

endpackage

[hw/rtl/lcfs_channels.sv]
// Valid/ready channel interfaces: pixel/tick requests, scan results and the config write.
// Depends on lcfs_pkg for the payload types.
interface lcfs_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [1:0] pos_x;
    logic [1:0] pos_y;
    logic [1:0] pos_z;
    logic [2:0] rgb;

    modport source (output valid, func, pos_x, pos_y, pos_z, rgb, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, rgb, output ready);
endinterface

interface lcfs_scan_if;
    logic                 valid;
    logic                 ready;
    lcfs_pkg::t_plane     plane_index;
    lcfs_pkg::t_word      shift_word;

    modport source (output valid, plane_index, shift_word, input ready);
    modport sink   (input valid, plane_index, shift_word, output ready);
endinterface

interface lcfs_cfg_if;
    logic                 valid;
    logic                 ready;
    lcfs_pkg::t_dwell     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/lcfs_frame_store.sv]
// Frame store: 8 planes of 24 anode bits, cleared at reset, with scattered pixel writes.
// Depends on lcfs_pkg for the bit placement table and the write request struct.
module lcfs_frame_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcfs_pkg::t_pix_wr i_wr,
    input  lcfs_pkg::t_plane  i_rd_plane,
    output lcfs_pkg::t_word   o_rd_word
);
    import lcfs_pkg::*;

    t_word r_plane_word [NUM_PLANES];
    t_word n_plane_word;

    // Merge the three color bits of the addressed sector into the plane word.
    always_comb begin
        n_plane_word = r_plane_word[i_wr.plane];
        for (int c = 0; c < NUM_COLORS; c++) begin
            n_plane_word[BIT_POS[i_wr.sector][c]] = i_wr.rgb[NUM_COLORS-1-c];
        end
    end

    // Plane registers; reset turns the cube dark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane_word[p] <= '0;
            end
        end else if (i_wr.en) begin
            r_plane_word[i_wr.plane] <= n_plane_word;
        end
    end

    // Read port for the scan sequencer.
    assign o_rd_word = r_plane_word[i_rd_plane];

endmodule

[hw/rtl/led_cube_frame_scan_core.sv]
// Top level of the LED cube frame scan core: request stage, scan sequencer, result register.
// Depends on lcfs_pkg, the channel interfaces and lcfs_frame_store.
//
// Usage:
//   i_req carries requests: func 0 writes the color rgb of pixel (pos_x, pos_y, pos_z)
//   into the frame store, func 1 is one scan tick (position and color are ignored).
//   o_scan carries one result at the first tick of each plane's dwell: the plane to
//   enable and its 24 anode bits, bits 23:16 shifted out first, MSB first.
//   i_cfg writes dwell_ticks, the ticks each plane stays lit (0 acts as 1). It is
//   always ready and is meant to be written while the core is idle.
// Pipeline and throughput:
//   A request is registered in the request register at acceptance and processed from
//   there; a tick's result passes the request register and then the result register,
//   where it can be taken. One request is taken every cycle while no result tick waits
//   on a stalled o_scan, set by the single request register feeding the state update.
// Reset:
//   Clears the frame store (cube dark), the scan plane and dwell count to zero, and
//   loads dwell_ticks with 1250.
// Stall:
//   While o_scan is held, ticks that need no result and pixel writes keep flowing;
//   a tick that produces a result waits in the request register, and i_req.ready
//   drops once that register cannot move on.
module led_cube_frame_scan_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcfs_req_if.sink    i_req,
    lcfs_cfg_if.sink    i_cfg,
    lcfs_scan_if.source o_scan
);
    import lcfs_pkg::*;

    // Request register.
    logic       r_s1_valid;
    logic       r_s1_func;
    logic [1:0] r_s1_x;
    logic [1:0] r_s1_y;
    logic [1:0] r_s1_z;
    logic [2:0] r_s1_rgb;

    // Scan state and configuration.
    t_plane r_scan_plane;
    t_dwell r_dwell_count;
    t_dwell r_dwell_ticks;
    t_plane n_scan_plane;
    t_dwell n_dwell_count;

    // Result register.
    logic   r_out_valid;
    t_plane r_out_plane;
    t_word  r_out_word;

    logic            s1_tick;
    logic            s1_needs_out;
    logic            out_free;
    logic            s1_adv;
    logic            req_accept;
    logic [DWELL_W:0] dwell_next;
    logic [DWELL_W:0] dwell_limit;
    t_pix_wr         pix_wr;
    t_word           rd_word;

    // Handshake and advance logic.
    assign s1_tick      = r_s1_valid && (r_s1_func == FUNC_TICK);
    assign s1_needs_out = s1_tick && (r_dwell_count == '0);
    assign out_free     = !r_out_valid || o_scan.ready;
    assign s1_adv       = r_s1_valid && (!s1_needs_out || out_free);
    assign i_req.ready  = !r_s1_valid || s1_adv;
    assign req_accept   = i_req.valid && i_req.ready;
    assign i_cfg.ready  = 1'b1;

    // Request register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_s1_func <= i_req.func;
            r_s1_x    <= i_req.pos_x;
            r_s1_y    <= i_req.pos_y;
            r_s1_z    <= i_req.pos_z;
            r_s1_rgb  <= i_req.rgb;
        end
    end

    // Pixel write: plane from z and the low bit of y, sector from x and the high bit of y.
    always_comb begin
        pix_wr.en     = s1_adv && (r_s1_func == FUNC_PIXEL);
        pix_wr.plane  = {r_s1_z, r_s1_y[0]};
        pix_wr.sector = {r_s1_x, r_s1_y[1]};
        pix_wr.rgb    = r_s1_rgb;
    end

    lcfs_frame_store u_frame_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (pix_wr),
        .i_rd_plane (r_scan_plane),
        .o_rd_word  (rd_word)
    );

    // Dwell counter: advance the plane once the incremented count reaches the limit.
    always_comb begin
        dwell_next  = {1'b0, r_dwell_count} + {{DWELL_W{1'b0}}, 1'b1};
        dwell_limit = (r_dwell_ticks == '0) ? {{DWELL_W{1'b0}}, 1'b1}
                                            : {1'b0, r_dwell_ticks};
        if (dwell_next >= dwell_limit) begin
            n_dwell_count = '0;
            n_scan_plane  = r_scan_plane + t_plane'(1);
        end else begin
            n_dwell_count = dwell_next[DWELL_W-1:0];
            n_scan_plane  = r_scan_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_plane  <= '0;
            r_dwell_count <= '0;
        end else if (s1_adv && s1_tick) begin
            r_scan_plane  <= n_scan_plane;
            r_dwell_count <= n_dwell_count;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell_ticks <= DWELL_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_dwell_ticks <= i_cfg.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && s1_needs_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_needs_out) begin
            r_out_plane <= r_scan_plane;
            r_out_word  <= rd_word;
        end
    end

    assign o_scan.valid       = r_out_valid;
    assign o_scan.plane_index = r_out_plane;
    assign o_scan.shift_word  = r_out_word;

    // A tick at the start of a dwell always leaves a result behind.
    a_tick_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_needs_out) |=> r_out_valid)
        else $error("dwell start tick did not produce a result");

    // The result carries the plane that was being scanned.
    a_result_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_needs_out) |=> (r_out_plane == $past(r_scan_plane)))
        else $error("result plane does not match scan plane");

    // The plane only moves when a dwell ends.
    a_plane_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_plane != $past(r_scan_plane)) |-> (r_dwell_count == '0))
        else $error("scan plane moved in the middle of a dwell");

    // A result never gets overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_needs_out) |-> out_free)
        else $error("result register overwritten while stalled");

endmodule
